/* hw/rtl/jse_pkg.sv */
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, opcodes, error codes and character constants of the JSON
// stream emitter.
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int MAX_DEPTH  = 32;
    localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int INT_W      = 32;
    localparam int CNT_W      = $clog2(INT_W);
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int MAIN_MAX   = BCD_DIGITS + 1;
    localparam int LEN_W      = 4;
    localparam int REM_W      = 4;
    localparam int CAP_W      = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd4096;

    localparam logic [3:0] OP_BEG_OBJ   = 4'd0;
    localparam logic [3:0] OP_END_OBJ   = 4'd1;
    localparam logic [3:0] OP_BEG_ARR   = 4'd2;
    localparam logic [3:0] OP_END_ARR   = 4'd3;
    localparam logic [3:0] OP_KEY_START = 4'd4;
    localparam logic [3:0] OP_KEY_CHAR  = 4'd5;
    localparam logic [3:0] OP_KEY_END   = 4'd6;
    localparam logic [3:0] OP_STR_START = 4'd7;
    localparam logic [3:0] OP_STR_CHAR  = 4'd8;
    localparam logic [3:0] OP_STR_END   = 4'd9;
    localparam logic [3:0] OP_INT       = 4'd10;
    localparam logic [3:0] OP_BOOL      = 4'd11;
    localparam logic [3:0] OP_NULL      = 4'd12;
    localparam logic [3:0] OP_RESTART   = 4'd13;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_STATE    = 2'd2;

    typedef logic [7:0] t_byte;
    typedef t_byte t_piece [MAIN_MAX];

    localparam t_byte CH_QUOTE  = 8'h22;
    localparam t_byte CH_BSLASH = 8'h5C;
    localparam t_byte CH_COMMA  = 8'h2C;
    localparam t_byte CH_COLON  = 8'h3A;
    localparam t_byte CH_LBRACE = 8'h7B;
    localparam t_byte CH_RBRACE = 8'h7D;
    localparam t_byte CH_LBRACK = 8'h5B;
    localparam t_byte CH_RBRACK = 8'h5D;
    localparam t_byte CH_MINUS  = 8'h2D;
    localparam t_byte CH_ZERO   = 8'h30;
    localparam t_byte CH_SPACE  = 8'h20;
    localparam t_byte CH_BS     = 8'h08;
    localparam t_byte CH_TAB    = 8'h09;
    localparam t_byte CH_LF     = 8'h0A;
    localparam t_byte CH_FF     = 8'h0C;
    localparam t_byte CH_CR     = 8'h0D;
    localparam t_byte CH_B      = 8'h62;
    localparam t_byte CH_T      = 8'h74;
    localparam t_byte CH_N      = 8'h6E;
    localparam t_byte CH_F      = 8'h66;
    localparam t_byte CH_R      = 8'h72;
    localparam t_byte CH_U      = 8'h75;
    localparam t_byte HEX_ALPHA = 8'h57;

    localparam logic [31:0] LIT_TRUE  = 32'h74727565;
    localparam logic [39:0] LIT_FALSE = 40'h66616C7365;
    localparam logic [31:0] LIT_NULL  = 32'h6E756C6C;

    typedef struct packed {
        logic [3:0]        opcode;
        logic [7:0]        char_byte;
        logic signed [31:0] int_value;
        logic              bool_value;
    } t_in_item;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       last;
        logic       ok;
        logic [1:0] error_code;
        logic [5:0] nesting;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic pre;
        logic main;
        logic pop;
    } t_dp_cmd;

    typedef struct packed {
        logic is_int;
        logic conv_done;
        logic last;
    } t_dp_stat;

    function automatic t_byte hex_char(input logic [3:0] nib);
        t_byte c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'h0, nib};
        end else begin
            c = HEX_ALPHA + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

/* hw/rtl/jse_bcd.sv */
// ----------------------------------------------------------------------------
// jse_bcd
// Binary to decimal converter: shift-and-add-3, one bit per cycle, then a
// left-justify pass that drops leading zero digits one digit per cycle.
// ----------------------------------------------------------------------------
module jse_bcd (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [jse_pkg::INT_W-1:0] i_mag,
    output logic                     o_done,
    output logic [jse_pkg::BCD_W-1:0] o_digits,
    output logic [jse_pkg::LEN_W-1:0] o_ndig
);
    import jse_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SHIFT,
        B_NORM
    } t_bcd_state;

    t_bcd_state       r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [INT_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [LEN_W-1:0] r_nd;
    logic             r_done;
    logic [BCD_W-1:0] adj;

    always_comb begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        r_bin   <= i_mag;
                        r_bcd   <= '0;
                        r_cnt   <= '0;
                        r_state <= B_SHIFT;
                    end
                end
                B_SHIFT: begin
                    r_bcd <= {adj[BCD_W-2:0], r_bin[INT_W-1]};
                    r_bin <= {r_bin[INT_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(INT_W - 1)) begin
                        r_nd    <= LEN_W'(BCD_DIGITS);
                        r_state <= B_NORM;
                    end
                end
                B_NORM: begin
                    if (r_bcd[BCD_W-1 -: 4] == 4'd0 && r_nd > LEN_W'(1)) begin
                        r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_nd  <= r_nd - 1'b1;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_digits = r_bcd;
    assign o_ndig   = r_nd;

endmodule

/* hw/rtl/jse_datapath.sv */
// ----------------------------------------------------------------------------
// jse_datapath
// Emitter state, container stack, piece build and capacity check, and the
// result byte queue.
// ----------------------------------------------------------------------------
module jse_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [jse_pkg::CAP_W-1:0] i_cfg_wr_data,
    input  jse_pkg::t_in_item        i_in_data,
    input  jse_pkg::t_dp_cmd         i_cmd,
    output jse_pkg::t_dp_stat        o_stat,
    output jse_pkg::t_out_item       o_out_data
);
    import jse_pkg::*;

    logic [CAP_W-1:0]   r_cap, n_cap;
    logic [CAP_W-1:0]   r_tl, n_tl;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_kp, n_kp;
    logic [1:0]         r_err, n_err;
    logic               r_abort, n_abort;
    logic               r_pre_em, n_pre_em;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic               r_has, n_has;
    logic               r_ok, n_ok;

    logic [3:0]         r_op, n_op;
    t_byte              r_char, n_char;
    logic               r_bool, n_bool;
    logic               r_neg, n_neg;
    t_byte              r_pre_char, n_pre_char;
    t_piece             r_main, n_main;

    logic               r_is_obj [MAX_DEPTH];
    logic               r_has_mem [MAX_DEPTH];

    logic [IDX_W-1:0]   top_idx, push_idx, hm_idx;
    logic               top_obj, top_mem;
    logic               hm_we, hm_val, io_we;
    logic               pre_req, pre_fits, main_take, main_fits, main_em;
    t_byte              pre_c;

    logic [INT_W-1:0]   in_raw, in_mag;
    logic               in_neg, conv_done;
    logic [BCD_W-1:0]   bcd_digits;
    logic [LEN_W-1:0]   bcd_ndig;

    t_byte              esc_b [6];
    logic [LEN_W-1:0]   esc_len;
    t_byte              int_dig [BCD_DIGITS];
    t_piece             main_b;
    logic [LEN_W-1:0]   main_len;
    t_byte              cur_byte;
    logic               out_last;

    assign in_raw = i_in_data.int_value;
    assign in_neg = in_raw[INT_W-1];
    assign in_mag = in_neg ? (~in_raw + 1'b1) : in_raw;

    jse_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.load && (i_in_data.opcode == OP_INT)),
        .i_mag    (in_mag),
        .o_done   (conv_done),
        .o_digits (bcd_digits),
        .o_ndig   (bcd_ndig)
    );

    assign top_idx  = IDX_W'(r_depth - DEPTH_W'(1));
    assign push_idx = IDX_W'(r_depth);
    assign top_obj  = r_is_obj[top_idx];
    assign top_mem  = r_has_mem[top_idx];

    // escaped form of a text byte
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            esc_b[k] = 8'h00;
        end
        esc_b[0] = CH_BSLASH;
        esc_len  = LEN_W'(2);
        case (r_char) inside
            CH_QUOTE:  esc_b[1] = CH_QUOTE;
            CH_BSLASH: esc_b[1] = CH_BSLASH;
            CH_LF:     esc_b[1] = CH_N;
            CH_TAB:    esc_b[1] = CH_T;
            CH_CR:     esc_b[1] = CH_R;
            CH_BS:     esc_b[1] = CH_B;
            CH_FF:     esc_b[1] = CH_F;
            default: begin
                if (r_char < CH_SPACE) begin
                    esc_b[1] = CH_U;
                    esc_b[2] = CH_ZERO;
                    esc_b[3] = CH_ZERO;
                    esc_b[4] = hex_char(r_char[7:4]);
                    esc_b[5] = hex_char(r_char[3:0]);
                    esc_len  = LEN_W'(6);
                end else begin
                    esc_b[0] = r_char;
                    esc_len  = LEN_W'(1);
                end
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            int_dig[k] = CH_ZERO + {4'h0, bcd_digits[BCD_W-1-4*k -: 4]};
        end
    end

    // main piece of the current command
    always_comb begin
        for (int k = 0; k < MAIN_MAX; k++) begin
            main_b[k] = 8'h00;
        end
        main_len = '0;
        unique case (r_op) inside
            OP_BEG_OBJ: begin
                main_b[0] = CH_LBRACE;
                main_len  = LEN_W'(1);
            end
            OP_BEG_ARR: begin
                main_b[0] = CH_LBRACK;
                main_len  = LEN_W'(1);
            end
            OP_END_OBJ: begin
                main_b[0] = CH_RBRACE;
                main_len  = LEN_W'(1);
            end
            OP_END_ARR: begin
                main_b[0] = CH_RBRACK;
                main_len  = LEN_W'(1);
            end
            OP_KEY_START, OP_STR_START, OP_STR_END: begin
                main_b[0] = CH_QUOTE;
                main_len  = LEN_W'(1);
            end
            OP_KEY_END: begin
                main_b[0] = CH_COLON;
                main_len  = LEN_W'(1);
            end
            OP_KEY_CHAR, OP_STR_CHAR: begin
                for (int k = 0; k < 6; k++) begin
                    main_b[k] = esc_b[k];
                end
                main_len = esc_len;
            end
            OP_INT: begin
                main_b[0] = r_neg ? CH_MINUS : int_dig[0];
                for (int j = 1; j < BCD_DIGITS; j++) begin
                    main_b[j] = r_neg ? int_dig[j-1] : int_dig[j];
                end
                main_b[BCD_DIGITS] = r_neg ? int_dig[BCD_DIGITS-1] : 8'h00;
                main_len = LEN_W'(r_neg) + bcd_ndig;
            end
            OP_BOOL: begin
                if (r_bool) begin
                    for (int k = 0; k < 4; k++) begin
                        main_b[k] = LIT_TRUE[31-8*k -: 8];
                    end
                    main_len = LEN_W'(4);
                end else begin
                    for (int k = 0; k < 5; k++) begin
                        main_b[k] = LIT_FALSE[39-8*k -: 8];
                    end
                    main_len = LEN_W'(5);
                end
            end
            OP_NULL: begin
                for (int k = 0; k < 4; k++) begin
                    main_b[k] = LIT_NULL[31-8*k -: 8];
                end
                main_len = LEN_W'(4);
            end
            default: main_len = '0;
        endcase
    end

    assign pre_fits  = (r_err == ERR_NONE) &&
                       (({1'b0, r_tl} + (CAP_W+1)'(1)) < {1'b0, r_cap});
    assign main_fits = (r_err == ERR_NONE) &&
                       (({1'b0, r_tl} + (CAP_W+1)'(main_len)) < {1'b0, r_cap});

    always_comb begin
        n_cap      = r_cap;
        n_tl       = r_tl;
        n_depth    = r_depth;
        n_kp       = r_kp;
        n_err      = r_err;
        n_abort    = r_abort;
        n_pre_em   = r_pre_em;
        n_rem      = r_rem;
        n_has      = r_has;
        n_ok       = r_ok;
        n_op       = r_op;
        n_char     = r_char;
        n_bool     = r_bool;
        n_neg      = r_neg;
        n_pre_char = r_pre_char;
        n_main     = r_main;
        hm_we      = 1'b0;
        hm_idx     = top_idx;
        hm_val     = 1'b1;
        io_we      = 1'b0;
        pre_req    = 1'b0;
        pre_c      = CH_COMMA;
        main_take  = 1'b0;
        main_em    = 1'b0;

        if (i_cfg_wr_en) begin
            n_cap = i_cfg_wr_data;
        end

        if (i_cmd.load) begin
            n_op     = i_in_data.opcode;
            n_char   = i_in_data.char_byte;
            n_bool   = i_in_data.bool_value;
            n_neg    = in_neg;
            n_abort  = 1'b0;
            n_pre_em = 1'b0;
            n_ok     = 1'b0;
        end

        // separator, key checks and stack pop
        if (i_cmd.pre) begin
            unique case (r_op) inside
                OP_BEG_OBJ, OP_BEG_ARR, OP_STR_START, OP_INT, OP_BOOL, OP_NULL: begin
                    if (r_kp) begin
                        n_kp = 1'b0;
                    end else if (r_depth != '0) begin
                        hm_we   = 1'b1;
                        pre_req = top_mem;
                    end
                end
                OP_KEY_START: begin
                    if (r_err != ERR_NONE) begin
                        n_abort = 1'b1;
                    end else if (r_depth == '0 || !top_obj) begin
                        n_err   = ERR_STATE;
                        n_abort = 1'b1;
                    end else begin
                        hm_we = 1'b1;
                        if (top_mem) begin
                            pre_req = 1'b1;
                            n_abort = !pre_fits;
                        end
                    end
                end
                OP_KEY_END: begin
                    pre_req = 1'b1;
                    pre_c   = CH_QUOTE;
                end
                OP_END_OBJ, OP_END_ARR: begin
                    if (r_depth == '0 || top_obj != (r_op == OP_END_OBJ)) begin
                        n_err   = ERR_STATE;
                        n_abort = 1'b1;
                    end else begin
                        n_depth = r_depth - 1'b1;
                    end
                end
                default: pre_req = 1'b0;
            endcase
            if (pre_req) begin
                if (pre_fits) begin
                    n_pre_em   = 1'b1;
                    n_pre_char = pre_c;
                    n_tl       = r_tl + 1'b1;
                end else if (r_err == ERR_NONE) begin
                    n_err = ERR_OVERFLOW;
                end
            end
        end

        // main piece, stack push and restart
        if (i_cmd.main) begin
            unique case (r_op) inside
                OP_BEG_OBJ, OP_BEG_ARR: begin
                    if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                        n_err = ERR_OVERFLOW;
                    end else begin
                        main_take = 1'b1;
                        if (main_fits) begin
                            io_we   = 1'b1;
                            hm_we   = 1'b1;
                            hm_idx  = push_idx;
                            hm_val  = 1'b0;
                            n_depth = r_depth + 1'b1;
                        end
                    end
                end
                OP_END_OBJ, OP_END_ARR, OP_KEY_START, OP_KEY_CHAR, OP_KEY_END,
                OP_STR_START, OP_STR_CHAR, OP_STR_END, OP_INT, OP_BOOL, OP_NULL: begin
                    main_take = !r_abort;
                    if (r_op == OP_KEY_END && main_fits) begin
                        n_kp = 1'b1;
                    end
                end
                OP_RESTART: begin
                    n_tl    = '0;
                    n_depth = '0;
                    n_kp    = 1'b0;
                    n_err   = ERR_NONE;
                    n_ok    = 1'b1;
                end
                default: main_take = 1'b0;
            endcase
            if (main_take) begin
                if (main_fits) begin
                    main_em = 1'b1;
                    n_main  = main_b;
                    n_tl    = r_tl + CAP_W'(main_len);
                    n_ok    = 1'b1;
                end else if (r_err == ERR_NONE) begin
                    n_err = ERR_OVERFLOW;
                end
            end
            n_rem = REM_W'(r_pre_em) + (main_em ? REM_W'(main_len) : REM_W'(0));
            n_has = (n_rem != '0);
        end

        if (i_cmd.pop && r_has) begin
            if (r_pre_em) begin
                n_pre_em = 1'b0;
            end else begin
                for (int k = 0; k < MAIN_MAX - 1; k++) begin
                    n_main[k] = r_main[k+1];
                end
            end
            n_rem = r_rem - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_tl     <= '0;
            r_depth  <= '0;
            r_kp     <= 1'b0;
            r_err    <= ERR_NONE;
            r_abort  <= 1'b0;
            r_pre_em <= 1'b0;
            r_rem    <= '0;
            r_has    <= 1'b0;
            r_ok     <= 1'b0;
        end else begin
            r_cap    <= n_cap;
            r_tl     <= n_tl;
            r_depth  <= n_depth;
            r_kp     <= n_kp;
            r_err    <= n_err;
            r_abort  <= n_abort;
            r_pre_em <= n_pre_em;
            r_rem    <= n_rem;
            r_has    <= n_has;
            r_ok     <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_char     <= n_char;
        r_bool     <= n_bool;
        r_neg      <= n_neg;
        r_pre_char <= n_pre_char;
        r_main     <= n_main;
        if (hm_we) begin
            r_has_mem[hm_idx] <= hm_val;
        end
        if (io_we) begin
            r_is_obj[push_idx] <= (r_op == OP_BEG_OBJ);
        end
    end

    assign cur_byte = r_pre_em ? r_pre_char : r_main[0];
    assign out_last = !r_has || (r_rem == REM_W'(1));

    assign o_out_data.has_byte   = r_has;
    assign o_out_data.out_byte   = r_has ? cur_byte : 8'h00;
    assign o_out_data.last       = out_last;
    assign o_out_data.ok         = r_ok;
    assign o_out_data.error_code = r_err;
    assign o_out_data.nesting    = 6'(r_depth);

    assign o_stat.is_int    = (i_in_data.opcode == OP_INT);
    assign o_stat.conv_done = conv_done;
    assign o_stat.last      = out_last;

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(MAX_DEPTH))
        else $error("nesting depth beyond stack size");

    a_count_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.main |=> (r_has == (r_rem != '0)))
        else $error("byte count and byte flag disagree");

endmodule

/* hw/rtl/jse_ctrl.sv */
// ----------------------------------------------------------------------------
// jse_ctrl
// Command sequencer: accept, integer conversion wait, separator step, main
// piece step, then result beats until the last one is taken.
// ----------------------------------------------------------------------------
module jse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  jse_pkg::t_dp_stat i_stat,
    output jse_pkg::t_dp_cmd  o_cmd
);
    import jse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_PRE,
        S_MAIN,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   accept;
    logic   pop;

    assign accept = i_in_valid && r_in_ready;
    assign pop    = r_out_valid && i_out_ready;

    assign o_cmd.load = accept;
    assign o_cmd.pre  = (r_state == S_PRE);
    assign o_cmd.main = (r_state == S_MAIN);
    assign o_cmd.pop  = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in_ready <= 1'b0;
                        r_state    <= i_stat.is_int ? S_CONV : S_PRE;
                    end
                end
                S_CONV: begin
                    if (i_stat.conv_done) begin
                        r_state <= S_PRE;
                    end
                end
                S_PRE: r_state <= S_MAIN;
                S_MAIN: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (pop && i_stat.last) begin
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_ready && r_out_valid))
        else $error("input and output open together");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !r_in_ready)
        else $error("second item taken while one is in work");

    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_stat.last) |=> (r_in_ready && !r_out_valid))
        else $error("no return to idle after last beat");

endmodule

/* hw/rtl/json_stream_emitter_top.sv */
// ----------------------------------------------------------------------------
// json_stream_emitter_top
// JSON text emitter: one building command in, its text bytes out one beat
// at a time, with separators, escapes and capacity checks.
// ----------------------------------------------------------------------------
// order: after accept the command runs the separator step and the main piece
//   step, integer commands first waiting on the one-bit-per-cycle decimal
//   converter; its result beats (1 to 12) then follow one at a time
// no new command is taken until the last result beat of the current one is taken
// reset: synchronous active low; clears length, depth, errors and key mark,
//   capacity returns to 4096; stack entries are not cleared
module json_stream_emitter_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [jse_pkg::CAP_W-1:0] i_cfg_wr_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  jse_pkg::t_in_item        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output jse_pkg::t_out_item       o_out_data
);
    import jse_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    jse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    jse_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_data    (o_out_data)
    );

endmodule
